// File: design/i2cm_pkg.sv
// shared types, codes and helpers for the i2c master bit engine
// used by i2cm_in_stage, i2cm_seq and i2c_master_bit_engine
package i2cm_pkg;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;

  localparam logic [7:0] CFG_PHASE_TICKS = 8'd0;
  localparam logic [7:0] CFG_ACK_LIMIT   = 8'd1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd20;
  localparam logic [7:0] ACK_LIMIT_RST   = 8'd250;

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_STA_HI  = 16'h0002,
    ST_STA_LO  = 16'h0004,
    ST_STP_LO  = 16'h0008,
    ST_STP_HI  = 16'h0010,
    ST_WR_SET  = 16'h0020,
    ST_WR_HI   = 16'h0040,
    ST_WR_LO   = 16'h0080,
    ST_WR_TAIL = 16'h0100,
    ST_RD_LO   = 16'h0200,
    ST_RD_HI   = 16'h0400,
    ST_AK_LO   = 16'h0800,
    ST_AK_HI   = 16'h1000,
    ST_WA_PRE  = 16'h2000,
    ST_WA_HI   = 16'h4000,
    ST_WA_POLL = 16'h8000
  } step_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic drv;
    logic sda;
    logic scl;
  } pins_t;

  typedef struct packed {
    logic       ack_fail;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_t;

  // released sda always reads as high
  function automatic pins_t set_pins(input logic scl, input logic sda, input logic drv);
    pins_t p;
    p.scl = scl;
    p.sda = drv ? sda : 1'b1;
    p.drv = drv;
    return p;
  endfunction

endpackage

// File: design/i2cm_in_stage.sv
// input register for tick items
// depends on i2cm_pkg
module i2cm_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  i2cm_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output i2cm_pkg::item_t item
);

  logic            valid_r, valid_nxt;
  i2cm_pkg::item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: design/i2cm_seq.sv
// bus sequencer: state registers and one-tick next-state logic
// depends on i2cm_pkg
module i2cm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  i2cm_pkg::item_t item,
  input  i2cm_pkg::cfg_t  cfg,
  output i2cm_pkg::res_t  res
);

  i2cm_pkg::step_t step_r, step_nxt;
  logic [7:0]      phase_r, phase_nxt;
  logic [3:0]      bit_r, bit_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [7:0]      poll_r, poll_nxt;
  i2cm_pkg::pins_t pins_r, pins_nxt;
  logic            ack_r, ack_nxt;
  logic [7:0]      rx_r, rx_nxt;
  logic            fail_r, fail_nxt;

  logic [7:0] full, half, pc_dec, shift_sh;
  logic       done, poll_now;

  assign full     = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
  assign half     = (full[7:1] == 7'd0) ? 8'd1 : {1'b0, full[7:1]};
  assign pc_dec   = (phase_r != 8'd0) ? phase_r - 8'd1 : 8'd0;
  assign shift_sh = {shift_r[6:0], 1'b0};

  always_comb begin
    step_nxt  = step_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    pins_nxt  = pins_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    fail_nxt  = fail_r;
    done      = 1'b0;
    poll_now  = 1'b0;

    if (step_r == i2cm_pkg::ST_IDLE) begin
      if (item.cmd_valid) begin
        case (item.opcode)
          i2cm_pkg::OP_START: begin
            pins_nxt  = i2cm_pkg::set_pins(1'b1, 1'b1, 1'b1);
            step_nxt  = i2cm_pkg::ST_STA_HI;
            phase_nxt = full;
          end
          i2cm_pkg::OP_STOP: begin
            pins_nxt  = i2cm_pkg::set_pins(1'b0, 1'b0, 1'b1);
            step_nxt  = i2cm_pkg::ST_STP_LO;
            phase_nxt = full;
          end
          i2cm_pkg::OP_WRITE: begin
            shift_nxt = item.tx_byte;
            bit_nxt   = 4'd0;
            pins_nxt  = i2cm_pkg::set_pins(1'b0, item.tx_byte[7], 1'b1);
            step_nxt  = i2cm_pkg::ST_WR_SET;
            phase_nxt = full;
          end
          i2cm_pkg::OP_READ: begin
            shift_nxt = 8'd0;
            bit_nxt   = 4'd0;
            ack_nxt   = item.send_ack;
            pins_nxt  = i2cm_pkg::set_pins(1'b0, 1'b1, 1'b0);
            step_nxt  = i2cm_pkg::ST_RD_LO;
            phase_nxt = full;
          end
          i2cm_pkg::OP_WAIT: begin
            poll_nxt  = 8'd0;
            pins_nxt  = i2cm_pkg::set_pins(pins_r.scl, 1'b1, 1'b0);
            step_nxt  = i2cm_pkg::ST_WA_PRE;
            phase_nxt = half;
          end
          default: begin
          end
        endcase
      end
    end else if (step_r == i2cm_pkg::ST_WA_POLL) begin
      poll_now = 1'b1;
    end else begin
      phase_nxt = pc_dec;
      if (pc_dec == 8'd0) begin
        case (step_r)
          i2cm_pkg::ST_STA_HI: begin
            pins_nxt  = i2cm_pkg::set_pins(1'b1, 1'b0, 1'b1);
            step_nxt  = i2cm_pkg::ST_STA_LO;
            phase_nxt = full;
          end
          i2cm_pkg::ST_STA_LO: begin
            pins_nxt = i2cm_pkg::set_pins(1'b0, 1'b0, 1'b1);
            step_nxt = i2cm_pkg::ST_IDLE;
            done     = 1'b1;
          end
          i2cm_pkg::ST_STP_LO: begin
            pins_nxt  = i2cm_pkg::set_pins(1'b1, 1'b1, 1'b1);
            step_nxt  = i2cm_pkg::ST_STP_HI;
            phase_nxt = full;
          end
          i2cm_pkg::ST_STP_HI, i2cm_pkg::ST_WR_TAIL: begin
            step_nxt = i2cm_pkg::ST_IDLE;
            done     = 1'b1;
          end
          i2cm_pkg::ST_WR_SET: begin
            pins_nxt  = i2cm_pkg::set_pins(1'b1, pins_r.sda, 1'b1);
            step_nxt  = i2cm_pkg::ST_WR_HI;
            phase_nxt = full;
          end
          i2cm_pkg::ST_WR_HI: begin
            pins_nxt  = i2cm_pkg::set_pins(1'b0, pins_r.sda, 1'b1);
            step_nxt  = i2cm_pkg::ST_WR_LO;
            phase_nxt = full;
          end
          i2cm_pkg::ST_WR_LO: begin
            bit_nxt   = bit_r + 4'd1;
            phase_nxt = full;
            if (bit_nxt < 4'd8) begin
              shift_nxt = shift_sh;
              pins_nxt  = i2cm_pkg::set_pins(1'b0, shift_sh[7], 1'b1);
              step_nxt  = i2cm_pkg::ST_WR_SET;
            end else begin
              step_nxt = i2cm_pkg::ST_WR_TAIL;
            end
          end
          i2cm_pkg::ST_RD_LO: begin
            pins_nxt  = i2cm_pkg::set_pins(1'b1, 1'b1, 1'b0);
            shift_nxt = {shift_r[6:0], item.sda_in};
            bit_nxt   = bit_r + 4'd1;
            step_nxt  = i2cm_pkg::ST_RD_HI;
            phase_nxt = full;
          end
          i2cm_pkg::ST_RD_HI: begin
            phase_nxt = full;
            if (bit_r < 4'd8) begin
              pins_nxt = i2cm_pkg::set_pins(1'b0, 1'b1, 1'b0);
              step_nxt = i2cm_pkg::ST_RD_LO;
            end else begin
              pins_nxt = i2cm_pkg::set_pins(1'b0, !ack_r, 1'b1);
              step_nxt = i2cm_pkg::ST_AK_LO;
            end
          end
          i2cm_pkg::ST_AK_LO: begin
            pins_nxt  = i2cm_pkg::set_pins(1'b1, pins_r.sda, 1'b1);
            step_nxt  = i2cm_pkg::ST_AK_HI;
            phase_nxt = full;
          end
          i2cm_pkg::ST_AK_HI: begin
            pins_nxt = i2cm_pkg::set_pins(1'b0, pins_r.sda, 1'b1);
            rx_nxt   = shift_r;
            step_nxt = i2cm_pkg::ST_IDLE;
            done     = 1'b1;
          end
          i2cm_pkg::ST_WA_PRE: begin
            pins_nxt  = i2cm_pkg::set_pins(1'b1, 1'b1, 1'b0);
            step_nxt  = i2cm_pkg::ST_WA_HI;
            phase_nxt = half;
          end
          i2cm_pkg::ST_WA_HI: begin
            poll_now = 1'b1;
          end
          default: begin
            step_nxt = i2cm_pkg::ST_IDLE;
          end
        endcase
      end
    end

    // ack poll: low ends the command, too many high polls force a stop
    if (poll_now) begin
      if (!item.sda_in) begin
        pins_nxt = i2cm_pkg::set_pins(1'b0, 1'b1, 1'b0);
        fail_nxt = 1'b0;
        step_nxt = i2cm_pkg::ST_IDLE;
        done     = 1'b1;
      end else if (poll_r >= cfg.ack_poll_limit) begin
        fail_nxt  = 1'b1;
        pins_nxt  = i2cm_pkg::set_pins(1'b0, 1'b0, 1'b1);
        step_nxt  = i2cm_pkg::ST_STP_LO;
        phase_nxt = full;
      end else begin
        poll_nxt = poll_r + 8'd1;
        step_nxt = i2cm_pkg::ST_WA_POLL;
      end
    end
  end

  always_comb begin
    res.scl_level = pins_nxt.scl;
    res.sda_level = pins_nxt.sda;
    res.sda_drive = pins_nxt.drv;
    res.busy_res  = (step_nxt != i2cm_pkg::ST_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_nxt;
    res.ack_fail  = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= i2cm_pkg::ST_IDLE;
      phase_r <= 8'd0;
      bit_r   <= 4'd0;
      shift_r <= 8'd0;
      poll_r  <= 8'd0;
      pins_r  <= i2cm_pkg::set_pins(1'b1, 1'b1, 1'b0);
      ack_r   <= 1'b0;
      rx_r    <= 8'd0;
      fail_r  <= 1'b0;
    end else if (step_en) begin
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      poll_r  <= poll_nxt;
      pins_r  <= pins_nxt;
      ack_r   <= ack_nxt;
      rx_r    <= rx_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

// File: design/i2c_master_bit_engine.sv
// i2c master bit engine: one tick item in, one pin/status item out
// path: input register, one-tick sequencer update, result register; throughput 1 item per cycle
// while out_tready does not hold back the result register
// synchronous active-low reset: sequencer idle, scl high, sda released,
// phase_ticks 20, ack_poll_limit 250, no items held
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
  input  logic [3:0]  in_tuser,   // cmd_valid[0], opcode[3:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_level, sda_level, sda_drive, busy_res, done_res,
                                  // rx_byte[12:5], ack_fail[13], zero[15:14]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  i2cm_pkg::item_t in_item, item;
  i2cm_pkg::cfg_t  cfg_r;
  i2cm_pkg::res_t  res, res_r;
  logic            item_valid, adv, out_valid_r, out_valid_nxt;

  assign in_item.cmd_valid = in_tuser[0];
  assign in_item.opcode    = in_tuser[3:1];
  assign in_item.tx_byte   = in_tdata[7:0];
  assign in_item.send_ack  = in_tdata[8];
  assign in_item.sda_in    = in_tdata[9];

  assign adv = item_valid && (!out_valid_r || out_tready);

  i2cm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (item),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks    <= i2cm_pkg::PHASE_TICKS_RST;
      cfg_r.ack_poll_limit <= i2cm_pkg::ACK_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == i2cm_pkg::CFG_PHASE_TICKS) begin
        cfg_r.phase_ticks <= cfg_data;
      end else if (cfg_index == i2cm_pkg::CFG_ACK_LIMIT) begin
        cfg_r.ack_poll_limit <= cfg_data;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.ack_fail, res_r.rx_byte, res_r.done_res, res_r.busy_res,
                       res_r.sda_drive, res_r.sda_level, res_r.scl_level};

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.done_res && res_r.busy_res))
    else $error("done and busy in the same item");

  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.sda_drive) |-> res_r.sda_level)
    else $error("released sda not reported high");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("sequencer step produced no result item");

endmodule
